/* rtl/sssp_pkg.sv */
// ----------------------------------------------------------------------------
// sssp_pkg
// Shared types, constants and command structs for the shortest path block.
// ----------------------------------------------------------------------------
package sssp_pkg;

  localparam int unsigned MaxVertices = 16;
  localparam int unsigned MaxEdges    = 64;
  localparam int unsigned WeightBits  = 16;
  localparam int unsigned DistBits    = 20;
  localparam int unsigned VidBits     = 4;
  localparam int unsigned CfgBits     = 5;

  // configuration register indexes
  localparam logic CfgStartVertex = 1'b0;
  localparam logic CfgVertexCount = 1'b1;

  typedef struct packed {
    logic [3:0]  from_vertex;
    logic [3:0]  to_vertex;
    logic [15:0] edge_weight;
    logic        has_edge;
    logic        last_edge;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  vertex_id;
    logic [19:0] path_length;
    logic [3:0]  predecessor;
    logic        reachable;
    logic        edges_dropped;
    logic        last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_RELAX,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic init;       // clear run state, seed start vertex
    logic scan_step;  // examine one vertex for the minimum
    logic scan_clr;   // restart the minimum search
    logic settle;     // settle the chosen vertex, reset edge pointer
    logic relax_step; // relax one stored edge
    logic emit_step;  // send one result
    logic clear_graph;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic relax_done;
    logic emit_done;
  } status_t;

endpackage

/* rtl/sssp_ctrl.sv */
// ----------------------------------------------------------------------------
// sssp_ctrl
// Sequencer: init, minimum scan, edge relaxation, result emission.
// ----------------------------------------------------------------------------
module sssp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             run_i,
  input  sssp_pkg::status_t status_i,
  output sssp_pkg::ctrl_t  ctrl_o,
  output logic             busy_o
);

  sssp_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sssp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      sssp_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (run_i) begin
          state_d = sssp_pkg::ST_INIT;
        end
      end
      sssp_pkg::ST_INIT: begin
        ctrl_o.init = 1'b1;
        state_d     = sssp_pkg::ST_SCAN;
      end
      sssp_pkg::ST_SCAN: begin
        if (status_i.scan_done) begin
          ctrl_o.scan_clr = 1'b1;
          if (status_i.found) begin
            ctrl_o.settle = 1'b1;
            state_d       = sssp_pkg::ST_RELAX;
          end else begin
            state_d = sssp_pkg::ST_EMIT;
          end
        end else begin
          ctrl_o.scan_step = 1'b1;
        end
      end
      sssp_pkg::ST_RELAX: begin
        if (status_i.relax_done) begin
          state_d = sssp_pkg::ST_SCAN;
        end else begin
          ctrl_o.relax_step = 1'b1;
        end
      end
      sssp_pkg::ST_EMIT: begin
        ctrl_o.emit_step = 1'b1;
        if (status_i.emit_done) begin
          ctrl_o.clear_graph = 1'b1;
          state_d            = sssp_pkg::ST_IDLE;
        end
      end
      default: state_d = sssp_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/sssp_dp.sv */
// ----------------------------------------------------------------------------
// sssp_dp
// Edge store, distance table, serial minimum scan and edge relaxation.
// ----------------------------------------------------------------------------
module sssp_dp #(
  parameter int unsigned MaxVertices = sssp_pkg::MaxVertices,
  parameter int unsigned MaxEdges    = sssp_pkg::MaxEdges,
  parameter int unsigned WeightBits  = sssp_pkg::WeightBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  sssp_pkg::in_item_t in_i,
  input  logic [3:0]         start_vertex_i,
  input  logic [4:0]         vertex_count_i,
  input  sssp_pkg::ctrl_t    ctrl_i,
  output sssp_pkg::status_t  status_o,
  output logic               res_valid_o,
  output sssp_pkg::out_item_t res_o
);

  localparam int unsigned VB = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned EB = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned FB = $clog2(MaxEdges + 1);
  localparam int unsigned CB = $clog2(MaxVertices + 1);
  localparam int unsigned DB = sssp_pkg::DistBits;
  localparam int unsigned SB = ((WeightBits > DB) ? WeightBits : DB) + 1;
  localparam logic [DB-1:0] DistMax = '1;

  // effective vertex count, clamped to 1..MaxVertices
  logic [CB-1:0] n_eff;
  always_comb begin
    if (vertex_count_i == '0) begin
      n_eff = CB'(1);
    end else if (32'(vertex_count_i) > MaxVertices) begin
      n_eff = CB'(MaxVertices);
    end else begin
      n_eff = CB'(vertex_count_i);
    end
  end

  // edge store memory
  logic [VB-1:0]         mem_src [MaxEdges];
  logic [VB-1:0]         mem_dst [MaxEdges];
  logic [WeightBits-1:0] mem_w   [MaxEdges];
  logic [FB-1:0]         fill_q;
  logic                  ovf_q;
  logic [FB-1:0]         eptr_q;
  logic [VB-1:0]         rd_src_q, rd_dst_q;
  logic [WeightBits-1:0] rd_w_q;
  logic                  rd_vld_q;

  logic [WeightBits-1:0] w_in;
  logic                  in_range, store_ok;
  assign w_in     = WeightBits'(in_i.edge_weight);
  assign in_range = (32'(in_i.from_vertex) < 32'(n_eff)) &&
                    (32'(in_i.to_vertex) < 32'(n_eff));
  assign store_ok = load_i && in_i.has_edge && in_range && (32'(fill_q) < MaxEdges);

  always_ff @(posedge clk_i) begin
    if (store_ok) begin
      mem_src[fill_q[EB-1:0]] <= VB'(in_i.from_vertex);
      mem_dst[fill_q[EB-1:0]] <= VB'(in_i.to_vertex);
      mem_w[fill_q[EB-1:0]]   <= w_in;
    end
    rd_src_q <= mem_src[eptr_q[EB-1:0]];
    rd_dst_q <= mem_dst[eptr_q[EB-1:0]];
    rd_w_q   <= mem_w[eptr_q[EB-1:0]];
  end

  // fill count and drop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
    end else if (ctrl_i.clear_graph) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      if (store_ok) begin
        fill_q <= fill_q + FB'(1);
      end
      if (load_i && in_i.has_edge && !store_ok) begin
        ovf_q <= 1'b1;
      end
    end
  end

  // run state
  logic [DB-1:0] dist_q [MaxVertices];
  logic [VB-1:0] par_q  [MaxVertices];
  logic [MaxVertices-1:0] fin_q, set_q;
  logic [CB-1:0] vptr_q;
  logic          found_q;
  logic [VB-1:0] pick_q;
  logic [DB-1:0] pick_d_q;

  logic [VB-1:0] vi;
  logic          cand;
  assign vi   = vptr_q[VB-1:0];
  assign cand = fin_q[vi] && !set_q[vi] && (!found_q || dist_q[vi] < pick_d_q);

  // relaxation of the edge read last cycle
  logic [SB-1:0] sum;
  logic [DB-1:0] nd;
  logic          rel_hit;
  assign sum     = SB'(dist_q[pick_q]) + SB'(rd_w_q);
  assign nd      = (sum > SB'(DistMax)) ? DistMax : sum[DB-1:0];
  assign rel_hit = rd_vld_q && (rd_src_q == pick_q) && (CB'(rd_dst_q) < n_eff)
                   && (!fin_q[rd_dst_q] || nd < dist_q[rd_dst_q]);

  logic          start_ok;
  logic [VB-1:0] start_idx;
  assign start_ok  = 32'(start_vertex_i) < 32'(n_eff);
  assign start_idx = VB'(start_vertex_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q    <= '0;
      set_q    <= '0;
      vptr_q   <= '0;
      found_q  <= 1'b0;
      eptr_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= ctrl_i.relax_step && (eptr_q < fill_q);
      if (ctrl_i.init) begin
        fin_q  <= '0;
        set_q  <= '0;
        vptr_q <= '0;
        found_q <= 1'b0;
        if (start_ok) begin
          fin_q[start_idx]  <= 1'b1;
          dist_q[start_idx] <= '0;
          par_q[start_idx]  <= start_idx;
        end
      end
      if (ctrl_i.scan_step) begin
        if (cand) begin
          found_q  <= 1'b1;
          pick_q   <= vi;
          pick_d_q <= dist_q[vi];
        end
        vptr_q <= vptr_q + CB'(1);
      end
      if (ctrl_i.scan_clr) begin
        vptr_q  <= '0;
        found_q <= 1'b0;
      end
      if (ctrl_i.settle) begin
        set_q[pick_q] <= 1'b1;
        eptr_q        <= '0;
      end
      if (ctrl_i.relax_step && (eptr_q < fill_q)) begin
        eptr_q <= eptr_q + FB'(1);
      end
      if (rel_hit) begin
        dist_q[rd_dst_q] <= nd;
        par_q[rd_dst_q]  <= pick_q;
        fin_q[rd_dst_q]  <= 1'b1;
      end
      if (ctrl_i.emit_step) begin
        vptr_q <= vptr_q + CB'(1);
      end
      if (ctrl_i.clear_graph) begin
        vptr_q <= '0;
      end
    end
  end

  always_comb begin
    status_o.scan_done  = (vptr_q >= n_eff);
    status_o.found      = found_q;
    status_o.relax_done = (eptr_q >= fill_q) && !rd_vld_q;
    status_o.emit_done  = (vptr_q + CB'(1) == n_eff);
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= ctrl_i.emit_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_step) begin
      res_o.vertex_id     <= 4'(vi);
      res_o.path_length   <= fin_q[vi] ? dist_q[vi] : '0;
      res_o.predecessor   <= fin_q[vi] ? 4'(par_q[vi]) : 4'd0;
      res_o.reachable     <= fin_q[vi];
      res_o.edges_dropped <= ovf_q;
      res_o.last_result   <= (vptr_q + CB'(1) == n_eff);
    end
  end

endmodule

/* rtl/single_source_shortest_path_top.sv */
// ----------------------------------------------------------------------------
// single_source_shortest_path_top
// Loads weighted edges, then runs a shortest path search and lists vertices.
// ----------------------------------------------------------------------------
// Edge items are taken one per cycle while busy is low. An item with
// last_edge set starts the search: busy rises and, after an init step, one
// scan over the vertices (N = vertex count) alternates with one pass over
// the stored edges for every settled vertex, ending with one last scan; the
// edge store has a single read port and the minimum scan is serial. Then N
// results follow on consecutive cycles, each marked by result_valid_o for
// one cycle; the receiver cannot stall them.
module single_source_shortest_path_top #(
  parameter int unsigned MaxVertices = sssp_pkg::MaxVertices,
  parameter int unsigned MaxEdges    = sssp_pkg::MaxEdges,
  parameter int unsigned WeightBits  = sssp_pkg::WeightBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  sssp_pkg::in_item_t  in_item_i,
  output logic                result_valid_o,
  output sssp_pkg::out_item_t result_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [4:0]          cfg_data_i
);

  logic [3:0]        start_vertex_q;
  logic [4:0]        vertex_count_q;
  logic              load;
  sssp_pkg::ctrl_t   ctrl;
  sssp_pkg::status_t status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_vertex_q <= '0;
      vertex_count_q <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sssp_pkg::CfgStartVertex: start_vertex_q <= cfg_data_i[3:0];
        sssp_pkg::CfgVertexCount: vertex_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign load = start && !busy;

  sssp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .run_i    (load && in_item_i.last_edge),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  sssp_dp #(
    .MaxVertices (MaxVertices),
    .MaxEdges    (MaxEdges),
    .WeightBits  (WeightBits)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .in_i           (in_item_i),
    .start_vertex_i (start_vertex_q),
    .vertex_count_i (vertex_count_q),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .res_valid_o    (result_valid_o),
    .res_o          (result_o)
  );

`ifndef ASSERT_OFF
  // results only come out of a run
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("result outside a run");
  // the last result ends the run
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_result |-> !busy) else $error("run did not end");
  // init, scan, relax and emit commands are exclusive
  a_cmd_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.init, ctrl.scan_step, ctrl.relax_step, ctrl.emit_step}))
    else $error("overlapping commands");
`endif

endmodule
